@@ rtl/acg_pkg.sv @@
// Package for the accelerometer calibration and gravity estimation block.
// Holds shared constants, state and command types. No dependencies.
`timescale 1ns / 1ps
package acg_pkg;

  localparam int unsigned SteadyMinDefault = 2;
  localparam logic [25:0] Len2Low  = 26'd13421773;
  localparam logic [25:0] Len2High = 26'd20132659;
  localparam logic [7:0]  ZeroReset = 8'd134;
  localparam logic [7:0]  SpanReset = 8'd28;

  // Configuration register indexes.
  localparam logic [2:0] RegZeroX = 3'd0;
  localparam logic [2:0] RegZeroY = 3'd1;
  localparam logic [2:0] RegZeroZ = 3'd2;
  localparam logic [2:0] RegSpanX = 3'd3;
  localparam logic [2:0] RegSpanY = 3'd4;
  localparam logic [2:0] RegSpanZ = 3'd5;

  typedef enum logic [3:0] {
    StIdle,
    StCalStart,
    StCalWait,
    StSquare,
    StCheck,
    StSqrtWait,
    StNormStart,
    StNormWait,
    StUpdate,
    StOut
  } acg_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;       // capture input sample
    logic       cal_start;  // start calibration divide for axis
    logic       sq_step;    // accumulate square of axis
    logic       sqrt_start; // start square root
    logic       norm_start; // start normalization divide for axis
    logic       grav_upd;   // commit new gravity vector
    logic       run_inc;    // in-window: bump run count
    logic       run_clr;    // out of window: clear run count
    logic [1:0] axis;
    logic       out_load;   // present result
  } acg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       div_done;
    logic       sqrt_done;
    logic       in_window;
    logic [1:0] run;
  } acg_stat_t;

endpackage

@@ rtl/acg_div.sv @@
// Iterative restoring divider with round-half-away-from-zero on a signed value.
// One quotient bit per cycle. Depends on nothing.
`timescale 1ns / 1ps
module acg_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               neg_i,   // sign of the numerator
  input  logic [31:0]        mag_i,   // numerator magnitude
  input  logic [17:0]        den_i,   // nonzero divisor
  output logic               done_o,
  output logic signed [33:0] quo_o
);
  // Computes q = (2*mag + den) / (2*den), signed by neg.
  logic [33:0] num_q, num_d;
  logic [34:0] rem_q, rem_d;
  logic [18:0] den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, neg_q, neg_d, done_q, done_d;
  logic [34:0] trial;

  always_comb begin
    num_d = num_q; rem_d = rem_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; neg_d = neg_q; done_d = 1'b0;
    trial = {rem_q[33:0], num_q[33]} - {16'd0, den_q};
    if (start_i) begin
      num_d  = {1'b0, mag_i, 1'b0} + {16'd0, den_i};
      den_d  = {den_i, 1'b0};
      rem_d  = '0;
      cnt_d  = 6'd34;
      busy_d = 1'b1;
      neg_d  = neg_i;
    end else if (busy_q) begin
      if (!trial[34]) begin
        rem_d = trial;
        num_d = {num_q[32:0], 1'b1};
      end else begin
        rem_d = {rem_q[33:0], num_q[33]};
        num_d = {num_q[32:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed(num_q) : $signed(num_q);
endmodule

@@ rtl/acg_sqrt.sv @@
// Iterative integer square root, two radicand bits per cycle.
// Depends on nothing.
`timescale 1ns / 1ps
module acg_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [33:0] val_i,
  output logic        done_o,
  output logic [16:0] root_o
);
  logic [33:0] v_q, v_d;
  logic [18:0] rem_q, rem_d;
  logic [16:0] res_q, res_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [18:0] cur, trial;

  always_comb begin
    v_d = v_q; rem_d = rem_q; res_d = res_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    cur   = {rem_q[16:0], v_q[33:32]};
    trial = cur - {res_q, 2'b01};
    if (start_i) begin
      v_d = val_i; rem_d = '0; res_d = '0; cnt_d = 5'd17; busy_d = 1'b1;
    end else if (busy_q) begin
      v_d = {v_q[31:0], 2'b00};
      if (!trial[18]) begin
        rem_d = trial;
        res_d = {res_q[15:0], 1'b1};
      end else begin
        rem_d = cur;
        res_d = {res_q[15:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    rem_q <= rem_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign root_o = res_q;
endmodule

@@ rtl/acg_datapath.sv @@
// Datapath: calibration registers, sample, shared divider, square root,
// length accumulation and gravity state. Depends on acg_pkg, acg_div, acg_sqrt.
`timescale 1ns / 1ps
module acg_datapath #(
  parameter int unsigned SteadyMin = acg_pkg::SteadyMinDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [7:0]         cfg_data_i,
  input  logic [7:0]         raw_a0_i,
  input  logic [7:0]         raw_a1_i,
  input  logic [7:0]         raw_a2_i,
  input  acg_pkg::acg_cmd_t  cmd_i,
  output acg_pkg::acg_stat_t stat_o,
  output logic               steady_o,
  output logic signed [15:0] accel_x_o,
  output logic signed [15:0] accel_y_o,
  output logic signed [15:0] accel_z_o,
  output logic signed [13:0] grav_x_o,
  output logic signed [13:0] grav_y_o,
  output logic signed [13:0] grav_z_o
);
  logic [7:0] zero_q [3];
  logic [7:0] span_q [3];
  logic [7:0] raw_q  [3];
  logic signed [15:0] acc_q [3];
  logic signed [13:0] grav_q [3];
  logic signed [13:0] gnew_q [3];
  logic [31:0] len2_q;
  logic [16:0] root_q;
  logic [1:0]  run_q;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        zero_q[i] <= acg_pkg::ZeroReset;
        span_q[i] <= acg_pkg::SpanReset;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        acg_pkg::RegZeroX: zero_q[0] <= cfg_data_i;
        acg_pkg::RegZeroY: zero_q[1] <= cfg_data_i;
        acg_pkg::RegZeroZ: zero_q[2] <= cfg_data_i;
        acg_pkg::RegSpanX: span_q[0] <= cfg_data_i;
        acg_pkg::RegSpanY: span_q[1] <= cfg_data_i;
        acg_pkg::RegSpanZ: span_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Numerator per output axis: x = zero0-raw0, y = zero2-raw2, z = raw1-zero1.
  logic signed [8:0] diff;
  logic [7:0]        span_sel;
  always_comb begin
    case (cmd_i.axis)
      2'd0: begin
        diff = $signed({1'b0, zero_q[0]}) - $signed({1'b0, raw_q[0]});
        span_sel = span_q[0];
      end
      2'd1: begin
        diff = $signed({1'b0, zero_q[2]}) - $signed({1'b0, raw_q[2]});
        span_sel = span_q[2];
      end
      default: begin
        diff = $signed({1'b0, raw_q[1]}) - $signed({1'b0, zero_q[1]});
        span_sel = span_q[1];
      end
    endcase
  end

  logic [8:0]  diff_mag;
  logic signed [15:0] acc_sel;
  assign diff_mag = diff[8] ? 9'(-diff) : 9'(diff);
  assign acc_sel  = acc_q[cmd_i.axis];

  // Shared divider input: calibration or normalization.
  logic        div_neg;
  logic [31:0] div_mag;
  logic [17:0] div_den;
  logic [16:0] acc_abs;
  assign acc_abs = acc_sel[15] ? 17'(-{{1{acc_sel[15]}}, acc_sel}) : 17'(acc_sel);
  always_comb begin
    if (cmd_i.norm_start) begin
      div_neg = acc_sel[15];
      div_mag = {acc_abs[15:0], 16'd0};
      div_den = {1'b0, root_q};
    end else begin
      div_neg = diff[8];
      div_mag = {11'd0, diff_mag, 12'd0};
      div_den = {10'd0, (span_sel == 8'd0) ? 8'd1 : span_sel};
    end
  end

  logic               div_done;
  logic signed [33:0] quo;
  acg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.cal_start | cmd_i.norm_start),
    .neg_i  (div_neg),
    .mag_i  (div_mag),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (quo)
  );

  // The root is only taken when the length is in the window, below 2^25.
  logic        sqrt_done;
  logic [16:0] root;
  acg_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.sqrt_start),
    .val_i  ({len2_q[25:0], 8'd0}),
    .done_o (sqrt_done),
    .root_o (root)
  );

  logic signed [15:0] sat16;
  logic signed [13:0] sat14;
  assign sat16 = (quo > 34'sd32767) ? 16'sh7FFF :
                 (quo < -34'sd32768) ? 16'sh8000 : 16'(quo);
  assign sat14 = (quo > 34'sd4096) ? 14'sd4096 :
                 (quo < -34'sd4096) ? -14'sd4096 : 14'(quo);

  // Square of the selected axis (magnitude up to 2^15); the sum of three
  // squares stays below 2^32.
  logic [16:0] sq_in;
  logic [33:0] sq;
  assign sq_in = acc_abs;
  assign sq    = sq_in * sq_in;
  logic [31:0] len_sum;
  assign len_sum = len2_q + sq[31:0];

  // Sample, results and length registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      raw_q[0] <= raw_a0_i;
      raw_q[1] <= raw_a1_i;
      raw_q[2] <= raw_a2_i;
      len2_q   <= '0;
    end
    if (div_done && !cmd_i.norm_start) begin
      if (cmd_i.sq_step) gnew_q[cmd_i.axis] <= sat14;
      else acc_q[cmd_i.axis] <= sat16;
    end
    if (cmd_i.sq_step && !div_done) len2_q <= len_sum;
    if (sqrt_done) root_q <= root;
  end

  // Gravity vector and run count state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q[0] <= '0;
      grav_q[1] <= -14'sd4096;
      grav_q[2] <= '0;
      run_q     <= '0;
    end else begin
      if (cmd_i.run_clr) run_q <= '0;
      else if (cmd_i.run_inc && run_q != 2'd3) run_q <= run_q + 2'd1;
      if (cmd_i.grav_upd) begin
        for (int i = 0; i < 3; i++) grav_q[i] <= gnew_q[i];
      end
    end
  end

  // Output registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      accel_x_o <= acc_q[0];
      accel_y_o <= acc_q[1];
      accel_z_o <= acc_q[2];
      grav_x_o  <= grav_q[0];
      grav_y_o  <= grav_q[1];
      grav_z_o  <= grav_q[2];
    end
  end

  assign stat_o.div_done  = div_done;
  assign stat_o.sqrt_done = sqrt_done;
  assign stat_o.in_window = (len2_q >= 32'(acg_pkg::Len2Low)) &&
                            (len2_q <= 32'(acg_pkg::Len2High));
  assign stat_o.run       = run_q;
  assign steady_o         = (32'(run_q) >= SteadyMin);
endmodule

@@ rtl/acg_ctrl.sv @@
// Controller state machine sequencing one sample through the datapath.
// Depends on acg_pkg.
`timescale 1ns / 1ps
module acg_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  acg_pkg::acg_stat_t stat_i,
  input  logic               steady_i,
  output acg_pkg::acg_cmd_t  cmd_o
);
  acg_pkg::acg_state_e state_q, state_d;
  logic [1:0] axis_q, axis_d;
  logic       oval_q, oval_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    case (state_q)
      acg_pkg::StIdle:
        if (in_valid && !in_stall) begin
          state_d = acg_pkg::StCalStart;
          axis_d  = 2'd0;
        end
      acg_pkg::StCalStart: state_d = acg_pkg::StCalWait;
      acg_pkg::StCalWait:
        if (stat_i.div_done) begin
          if (axis_q == 2'd2) begin
            state_d = acg_pkg::StSquare;
            axis_d  = 2'd0;
          end else begin
            state_d = acg_pkg::StCalStart;
            axis_d  = axis_q + 2'd1;
          end
        end
      acg_pkg::StSquare:
        if (axis_q == 2'd2) state_d = acg_pkg::StCheck;
        else axis_d = axis_q + 2'd1;
      acg_pkg::StCheck:
        state_d = stat_i.in_window ? acg_pkg::StSqrtWait : acg_pkg::StOut;
      acg_pkg::StSqrtWait:
        if (!steady_i) state_d = acg_pkg::StOut;
        else if (stat_i.sqrt_done) begin
          state_d = acg_pkg::StNormStart;
          axis_d  = 2'd0;
        end
      acg_pkg::StNormStart: state_d = acg_pkg::StNormWait;
      acg_pkg::StNormWait:
        if (stat_i.div_done) begin
          if (axis_q == 2'd2) state_d = acg_pkg::StUpdate;
          else begin
            state_d = acg_pkg::StNormStart;
            axis_d  = axis_q + 2'd1;
          end
        end
      acg_pkg::StUpdate: state_d = acg_pkg::StOut;
      acg_pkg::StOut:
        if (!oval_q || !out_stall) state_d = acg_pkg::StIdle;
      default: state_d = acg_pkg::StIdle;
    endcase
  end

  // Output valid holds until taken.
  always_comb begin
    oval_d = oval_q;
    if (oval_q && !out_stall) oval_d = 1'b0;
    if (state_q == acg_pkg::StOut && (!oval_q || !out_stall)) oval_d = 1'b1;
  end

  // Commands. During normalization sq_step steers the quotient into the
  // new gravity registers.
  always_comb begin
    cmd_o = '0;
    cmd_o.axis = axis_q;
    case (state_q)
      acg_pkg::StIdle:      cmd_o.load = in_valid && !in_stall;
      acg_pkg::StCalStart:  cmd_o.cal_start = 1'b1;
      acg_pkg::StSquare:    cmd_o.sq_step = 1'b1;
      acg_pkg::StCheck: begin
        cmd_o.run_inc    = stat_i.in_window;
        cmd_o.run_clr    = !stat_i.in_window;
        cmd_o.sqrt_start = stat_i.in_window;
      end
      acg_pkg::StNormStart: cmd_o.norm_start = 1'b1;
      acg_pkg::StNormWait:  cmd_o.sq_step = 1'b1;
      acg_pkg::StUpdate:    cmd_o.grav_upd = 1'b1;
      acg_pkg::StOut:       cmd_o.out_load = !oval_q || !out_stall;
      default: ;
    endcase
  end

  assign in_stall  = (state_q != acg_pkg::StIdle);
  assign out_valid = oval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= acg_pkg::StIdle;
      axis_q  <= '0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      oval_q  <= oval_d;
    end
  end
endmodule

@@ rtl/accel_calibrate_gravity_estimate_top.sv @@
// Top level of the accelerometer calibration and gravity estimation block.
// Depends on acg_pkg, acg_ctrl and acg_datapath.
`timescale 1ns / 1ps
// One request is one raw three-axis sample. It is calibrated per axis with a
// shared divider (three divides), squared and summed, and when the squared
// length is in the steady window for SteadyMin samples a square root and three
// more divides renormalize the gravity vector. Input stall is high while a
// sample is in work; the finished result sits in an output register.
module accel_calibrate_gravity_estimate_top #(
  parameter int unsigned SteadyMin = acg_pkg::SteadyMinDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         raw_a0_i,
  input  logic [7:0]         raw_a1_i,
  input  logic [7:0]         raw_a2_i,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] accel_x_o,
  output logic signed [15:0] accel_y_o,
  output logic signed [15:0] accel_z_o,
  output logic signed [13:0] grav_x_o,
  output logic signed [13:0] grav_y_o,
  output logic signed [13:0] grav_z_o
);
  acg_pkg::acg_cmd_t  cmd;
  acg_pkg::acg_stat_t stat;
  logic               steady;

  acg_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .stat_i   (stat),
    .steady_i (steady),
    .cmd_o    (cmd)
  );

  acg_datapath #(.SteadyMin(SteadyMin)) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .raw_a0_i  (raw_a0_i),
    .raw_a1_i  (raw_a1_i),
    .raw_a2_i  (raw_a2_i),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .steady_o  (steady),
    .accel_x_o (accel_x_o),
    .accel_y_o (accel_y_o),
    .accel_z_o (accel_z_o),
    .grav_x_o  (grav_x_o),
    .grav_y_o  (grav_y_o),
    .grav_z_o  (grav_z_o)
  );
endmodule
